### rtl/core/cfbd_pkg.sv
package cfbd_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hF1;
    localparam logic [7:0] CMD_CLASSIC = 8'd0;
    localparam logic [7:0] CMD_FD      = 8'd20;

    localparam logic [7:0] RPL_CODE_01 = 8'd1;
    localparam logic [7:0] RPL_CODE_02 = 8'd2;
    localparam logic [7:0] RPL_CODE_03 = 8'd3;
    localparam logic [7:0] RPL_CODE_04 = 8'd4;
    localparam logic [7:0] RPL_CODE_05 = 8'd5;
    localparam logic [7:0] RPL_CODE_06 = 8'd6;
    localparam logic [7:0] RPL_CODE_07 = 8'd7;
    localparam logic [7:0] RPL_CODE_09 = 8'd9;
    localparam logic [7:0] RPL_CODE_12 = 8'd12;
    localparam logic [7:0] RPL_CODE_13 = 8'd13;
    localparam logic [7:0] RPL_CODE_22 = 8'd22;

    localparam logic [6:0] STEP_LEN_BYTE  = 7'd8;
    localparam logic [6:0] STEP_BUS_BYTE  = 7'd9;
    localparam logic [6:0] CLASSIC_DATA0  = 7'd9;
    localparam logic [6:0] FD_DATA0       = 7'd10;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMD,
        PH_CLASSIC,
        PH_FD
    } t_phase;

    typedef struct packed {
        logic [31:0] time_stamp;
        logic [30:0] frame_id;
        logic        extended_id;
        logic        flexible_rate;
        logic [7:0]  bus_number;
        logic [5:0]  data_length;
        logic [5:0]  byte_index;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
    } t_result;

endpackage

### rtl/core/cfbd_core.sv
module cfbd_core
    import cfbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [6:0]  r_step, n_step;
    logic [31:0] r_stamp, n_stamp;
    logic [31:0] r_ident, n_ident;
    logic [5:0]  r_len, n_len;
    logic [7:0]  r_bus, n_bus;
    logic        r_fd, n_fd;

    logic [6:0] w_len7;
    logic [6:0] w_classic_end;
    logic [6:0] w_fd_end;
    logic [6:0] w_classic_idx;
    logic [6:0] w_fd_idx;
    logic       w_reply;

    assign w_len7        = {1'b0, r_len};
    assign w_classic_end = w_len7 + CLASSIC_DATA0;
    assign w_fd_end      = w_len7 + FD_DATA0;
    assign w_classic_idx = r_step - CLASSIC_DATA0;
    assign w_fd_idx      = r_step - FD_DATA0;
    assign w_reply       = i_byte inside {RPL_CODE_01, RPL_CODE_02, RPL_CODE_03, RPL_CODE_04,
                                          RPL_CODE_05, RPL_CODE_06, RPL_CODE_07, RPL_CODE_09,
                                          RPL_CODE_12, RPL_CODE_13, RPL_CODE_22};

    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_stamp = r_stamp;
        n_ident = r_ident;
        n_len   = r_len;
        n_bus   = r_bus;
        n_fd    = r_fd;
        case (r_phase)
            PH_IDLE: begin
                if (i_byte == SYNC_BYTE) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (i_byte == CMD_CLASSIC) begin
                    n_phase = PH_CLASSIC;
                    n_step  = '0;
                    n_fd    = 1'b0;
                end else if (i_byte == CMD_FD) begin
                    n_phase = PH_FD;
                    n_step  = '0;
                    n_fd    = 1'b1;
                end else if (w_reply) begin
                    n_phase = PH_IDLE;
                    n_step  = '0;
                end
            end
            PH_CLASSIC, PH_FD: begin
                if (r_step < STEP_LEN_BYTE) begin
                    if (!r_step[2]) begin
                        if (r_step[1:0] == 2'd0) begin
                            n_stamp = {24'd0, i_byte};
                        end else begin
                            n_stamp[{r_step[1:0], 3'b000} +: 8] = i_byte;
                        end
                    end else begin
                        if (r_step[1:0] == 2'd0) begin
                            n_ident = {24'd0, i_byte};
                        end else begin
                            n_ident[{r_step[1:0], 3'b000} +: 8] = i_byte;
                        end
                    end
                    n_step = r_step + 7'd1;
                end else if (r_phase == PH_CLASSIC) begin
                    if (r_step == STEP_LEN_BYTE) begin
                        n_len = {2'b00, i_byte[3:0]};
                        n_bus = {4'd0, i_byte[7:4]};
                        if (i_byte[3:0] == 4'd0) begin
                            n_phase = PH_IDLE;
                            n_step  = '0;
                        end else begin
                            n_step = CLASSIC_DATA0;
                        end
                    end else if (r_step < w_classic_end) begin
                        if (r_step == w_classic_end - 7'd1) begin
                            n_phase = PH_IDLE;
                            n_step  = '0;
                        end else begin
                            n_step = r_step + 7'd1;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                        n_step  = '0;
                    end
                end else begin
                    if (r_step == STEP_LEN_BYTE) begin
                        n_len  = i_byte[5:0];
                        n_step = STEP_BUS_BYTE;
                    end else if (r_step == STEP_BUS_BYTE) begin
                        n_bus  = i_byte;
                        n_step = FD_DATA0;
                    end else if (r_step < w_fd_end) begin
                        n_step = r_step + 7'd1;
                    end else begin
                        n_phase = PH_IDLE;
                        n_step  = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_comb begin
        o_res_valid         = 1'b0;
        o_res.time_stamp    = r_stamp;
        o_res.frame_id      = r_ident[30:0];
        o_res.extended_id   = r_ident[31];
        o_res.flexible_rate = r_fd;
        o_res.bus_number    = r_bus;
        o_res.data_length   = r_len;
        o_res.byte_index    = '0;
        o_res.data_byte     = '0;
        o_res.has_data      = 1'b0;
        o_res.last          = 1'b0;
        case (r_phase)
            PH_CLASSIC: begin
                if (r_step == STEP_LEN_BYTE) begin
                    o_res.bus_number  = {4'd0, i_byte[7:4]};
                    o_res.data_length = {2'b00, i_byte[3:0]};
                    o_res.last        = 1'b1;
                    o_res_valid       = (i_byte[3:0] == 4'd0);
                end else if (r_step > STEP_LEN_BYTE && r_step < w_classic_end) begin
                    o_res_valid      = 1'b1;
                    o_res.has_data   = 1'b1;
                    o_res.byte_index = w_classic_idx[5:0];
                    o_res.data_byte  = i_byte;
                    o_res.last       = (r_step == w_classic_end - 7'd1);
                end
            end
            PH_FD: begin
                if (r_step == STEP_BUS_BYTE) begin
                    o_res.bus_number = i_byte;
                    o_res.last       = 1'b1;
                    o_res_valid      = (r_len == 6'd0);
                end else if (r_step > STEP_BUS_BYTE && r_step < w_fd_end) begin
                    o_res_valid      = 1'b1;
                    o_res.has_data   = 1'b1;
                    o_res.byte_index = w_fd_idx[5:0];
                    o_res.data_byte  = i_byte;
                    o_res.last       = (r_step == w_fd_end - 7'd1);
                end
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        o_res_valid = o_res_valid && i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_stamp <= '0;
            r_ident <= '0;
            r_len   <= '0;
            r_bus   <= '0;
            r_fd    <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_stamp <= n_stamp;
            r_ident <= n_ident;
            r_len   <= n_len;
            r_bus   <= n_bus;
            r_fd    <= n_fd;
        end
    end

endmodule

### rtl/core/cfbd_out_reg.sv
module cfbd_out_reg
    import cfbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/core/can_frame_byte_deframer.sv
// Deframer for CAN and CAN FD frames carried in a byte-wide binary serial stream.
// The input channel takes one received byte per beat on i_rx_byte, qualified by
// i_in_valid and held off by o_in_stall. The output channel gives one beat per data
// byte of a frame, with the frame header fields repeated on every beat, and a single
// beat with has_data low for a frame of zero length; last marks the frame's end.
// A beat is taken on either channel at a rising edge where valid is high and stall
// is low.
// Each accepted byte passes through an input register and then the decode logic into
// the output register. One byte can be accepted in every cycle while the receiver
// does not stall the output; the single decode step per byte sets this.
// When the receiver stalls, the output beat holds; o_in_stall rises at once if the
// input register holds a byte, and else one more byte is still taken into it first.
// Synchronous reset returns the decoder to waiting for a sync byte and empties both
// registers; stored header fields clear to zero, but the output fields are not reset.
module can_frame_byte_deframer
    import cfbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_time_stamp,
    output logic [30:0] o_frame_id,
    output logic        o_extended_id,
    output logic        o_flexible_rate,
    output logic [7:0]  o_bus_number,
    output logic [5:0]  o_data_length,
    output logic [5:0]  o_byte_index,
    output logic [7:0]  o_data_byte,
    output logic        o_has_data,
    output logic        o_last
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       w_advance;
    logic       w_accept;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    assign w_advance  = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_step     = r_in_valid && w_advance;

    always_comb begin
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    cfbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cfbd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (w_out)
    );

    assign o_time_stamp    = w_out.time_stamp;
    assign o_frame_id      = w_out.frame_id;
    assign o_extended_id   = w_out.extended_id;
    assign o_flexible_rate = w_out.flexible_rate;
    assign o_bus_number    = w_out.bus_number;
    assign o_data_length   = w_out.data_length;
    assign o_byte_index    = w_out.byte_index;
    assign o_data_byte     = w_out.data_byte;
    assign o_has_data      = w_out.has_data;
    assign o_last          = w_out.last;

endmodule

### rtl/core/cfbd_checker.sv
module cfbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_flexible_rate,
    input logic [7:0] o_bus_number,
    input logic [5:0] o_data_length,
    input logic [5:0] o_byte_index,
    input logic [7:0] o_data_byte,
    input logic       o_has_data,
    input logic       o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_byte_index) && $stable(o_last))
        else $error("Stalled output beat changed.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_data |-> o_last && o_data_length == 6'd0
            && o_byte_index == 6'd0 && o_data_byte == 8'd0)
        else $error("Empty-frame beat is malformed.");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_data |-> o_byte_index < o_data_length)
        else $error("Byte index lies outside the frame.");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_data |-> o_last == (o_byte_index == o_data_length - 6'd1))
        else $error("Last flag does not match the final data byte.");

    a_classic_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_flexible_rate |-> o_bus_number[7:4] == 4'd0
            && o_data_length[5:4] == 2'd0)
        else $error("Classic frame carries an out-of-range bus or length.");

endmodule

bind can_frame_byte_deframer cfbd_checker u_cfbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_flexible_rate (o_flexible_rate),
    .o_bus_number    (o_bus_number),
    .o_data_length   (o_data_length),
    .o_byte_index    (o_byte_index),
    .o_data_byte     (o_data_byte),
    .o_has_data      (o_has_data),
    .o_last          (o_last)
);

### tb/sv/tb_top.sv
module tb_top;
    import cfbd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1500;
    localparam int QUIET_ITEMS = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_time_stamp;
    logic [30:0] o_frame_id;
    logic        o_extended_id;
    logic        o_flexible_rate;
    logic [7:0]  o_bus_number;
    logic [5:0]  o_data_length;
    logic [5:0]  o_byte_index;
    logic [7:0]  o_data_byte;
    logic        o_has_data;
    logic        o_last;

    can_frame_byte_deframer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_time_stamp    (o_time_stamp),
        .o_frame_id      (o_frame_id),
        .o_extended_id   (o_extended_id),
        .o_flexible_rate (o_flexible_rate),
        .o_bus_number    (o_bus_number),
        .o_data_length   (o_data_length),
        .o_byte_index    (o_byte_index),
        .o_data_byte     (o_data_byte),
        .o_has_data      (o_has_data),
        .o_last          (o_last)
    );

    localparam logic [7:0] REPLY_CODES [11] = '{
        RPL_CODE_01, RPL_CODE_02, RPL_CODE_03, RPL_CODE_04, RPL_CODE_05, RPL_CODE_06,
        RPL_CODE_07, RPL_CODE_09, RPL_CODE_12, RPL_CODE_13, RPL_CODE_22
    };

    // Decoder state as tracked by the testbench.
    t_phase      dec_phase = PH_IDLE;
    logic [6:0]  dec_step  = '0;
    logic [31:0] dec_stamp = '0;
    logic [31:0] dec_ident = '0;
    logic [5:0]  dec_len   = '0;
    logic [7:0]  dec_bus   = '0;
    logic        dec_fd    = 1'b0;

    t_result     pending_beats [$];
    t_result     head_beat;
    int          error_count = 0;
    int          items_taken = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          idling      = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic bit is_reply_code(input logic [7:0] code);
        foreach (REPLY_CODES[k]) begin
            if (REPLY_CODES[k] == code) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic queue_beat(input bit has, input logic [5:0] idx, input logic [7:0] val,
                              input bit fin);
        t_result r;
        r.time_stamp    = dec_stamp;
        r.frame_id      = dec_ident[30:0];
        r.extended_id   = dec_ident[31];
        r.flexible_rate = dec_fd;
        r.bus_number    = dec_bus;
        r.data_length   = dec_len;
        r.byte_index    = has ? idx : 6'd0;
        r.data_byte     = has ? val : 8'd0;
        r.has_data      = has;
        r.last          = fin;
        pending_beats.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] c);
        logic [6:0] s;
        logic [6:0] len;
        logic [6:0] idx;
        s   = dec_step;
        len = {1'b0, dec_len};
        items_taken++;
        case (dec_phase)
            PH_IDLE: begin
                if (c == SYNC_BYTE) dec_phase = PH_CMD;
            end
            PH_CMD: begin
                if (c == CMD_CLASSIC) begin
                    dec_phase = PH_CLASSIC;
                    dec_step  = '0;
                    dec_fd    = 1'b0;
                end else if (c == CMD_FD) begin
                    dec_phase = PH_FD;
                    dec_step  = '0;
                    dec_fd    = 1'b1;
                end else if (is_reply_code(c)) begin
                    dec_phase = PH_IDLE;
                    dec_step  = '0;
                end
            end
            default: begin
                if (s < STEP_LEN_BYTE) begin
                    if (s < 7'd4) begin
                        if (s == 7'd0) dec_stamp = {24'h0, c};
                        else dec_stamp[8*s[1:0] +: 8] = c;
                    end else begin
                        if (s == 7'd4) dec_ident = {24'h0, c};
                        else dec_ident[8*s[1:0] +: 8] = c;
                    end
                    dec_step = s + 7'd1;
                end else if (dec_phase == PH_CLASSIC) begin
                    if (s == STEP_LEN_BYTE) begin
                        dec_len = {2'b00, c[3:0]};
                        dec_bus = {4'h0, c[7:4]};
                        if (dec_len == 6'd0) begin
                            queue_beat(1'b0, 6'd0, 8'd0, 1'b1);
                            dec_phase = PH_IDLE;
                            dec_step  = '0;
                        end else begin
                            dec_step = CLASSIC_DATA0;
                        end
                    end else if (s < len + CLASSIC_DATA0) begin
                        idx = s - CLASSIC_DATA0;
                        queue_beat(1'b1, idx[5:0], c, s == len + 7'd8);
                        if (s == len + 7'd8) begin
                            dec_phase = PH_IDLE;
                            dec_step  = '0;
                        end else begin
                            dec_step = s + 7'd1;
                        end
                    end else begin
                        dec_phase = PH_IDLE;
                        dec_step  = '0;
                    end
                end else begin
                    if (s == STEP_LEN_BYTE) begin
                        dec_len  = c[5:0];
                        dec_step = STEP_BUS_BYTE;
                    end else if (s == STEP_BUS_BYTE) begin
                        dec_bus = c;
                        if (len == 7'd0) queue_beat(1'b0, 6'd0, 8'd0, 1'b1);
                        dec_step = FD_DATA0;
                    end else if (s < len + FD_DATA0) begin
                        idx = s - FD_DATA0;
                        queue_beat(1'b1, idx[5:0], c, s == len + 7'd9);
                        dec_step = s + 7'd1;
                    end else begin
                        dec_phase = PH_IDLE;
                        dec_step  = '0;
                    end
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] c);
        if (idling && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(c);
    endtask

    task automatic send_frame(input bit is_fd, input logic [5:0] len, input logic [31:0] stamp_v,
                              input logic [31:0] id_v, input logic [7:0] bus_v,
                              input logic [1:0] len_pad);
        send_byte(SYNC_BYTE);
        send_byte(is_fd ? CMD_FD : CMD_CLASSIC);
        for (int k = 0; k < 4; k++) send_byte(stamp_v[8*k +: 8]);
        for (int k = 0; k < 4; k++) send_byte(id_v[8*k +: 8]);
        if (is_fd) begin
            send_byte({len_pad, len});
            send_byte(bus_v);
        end else begin
            send_byte({bus_v[3:0], len[3:0]});
        end
        for (int k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)));
        if (is_fd) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                $error("result beat arrived with none expected");
                error_count++;
            end else begin
                head_beat = pending_beats.pop_front();
                check_field("time_stamp", head_beat.time_stamp, o_time_stamp);
                check_field("frame_id", 32'(head_beat.frame_id), 32'(o_frame_id));
                check_field("extended_id", 32'(head_beat.extended_id), 32'(o_extended_id));
                check_field("flexible_rate", 32'(head_beat.flexible_rate),
                            32'(o_flexible_rate));
                check_field("bus_number", 32'(head_beat.bus_number), 32'(o_bus_number));
                check_field("data_length", 32'(head_beat.data_length), 32'(o_data_length));
                check_field("byte_index", 32'(head_beat.byte_index), 32'(o_byte_index));
                check_field("data_byte", 32'(head_beat.data_byte), 32'(o_data_byte));
                check_field("has_data", 32'(head_beat.has_data), 32'(o_has_data));
                check_field("last", 32'(head_beat.last), 32'(o_last));
            end
        end
    end

    task automatic test_command_codes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CMD_FD);
        foreach (REPLY_CODES[k]) begin
            send_byte(SYNC_BYTE);
            send_byte(REPLY_CODES[k]);
        end
        // Unknown codes, a repeated sync byte among them, keep the decoder waiting.
        send_byte(SYNC_BYTE);
        send_byte(8'd8);
        send_byte(8'hFF);
        send_byte(SYNC_BYTE);
        send_byte(8'd21);
        send_byte(RPL_CODE_22);
    endtask

    task automatic test_classic_frames();
        send_frame(1'b0, 6'd0, 32'h0000_0000, 32'h0000_0000, 8'h00, 2'b00);
        send_frame(1'b0, 6'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0F, 2'b00);
        send_frame(1'b0, 6'd8, 32'h1234_5678, 32'h0000_07FF, 8'h05, 2'b00);
    endtask

    task automatic test_fd_frames();
        send_frame(1'b1, 6'd0, 32'hA5A5_5A5A, 32'h8000_0000, 8'hFF, 2'b11);
        send_frame(1'b1, 6'd63, 32'h0102_0304, 32'h1FFF_FFFF, 8'h80, 2'b11);
        send_frame(1'b1, 6'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'h00, 2'b00);
    endtask

    task automatic test_pause_for_results();
        wait_results_done();
        repeat ($urandom_range(1, 15)) @(posedge i_clk);
    endtask

    task automatic test_random_traffic();
        bit         is_fd;
        logic [5:0] len;
        while (items_taken < ITEM_TARGET) begin
            if (items_taken > ITEM_TARGET - QUIET_ITEMS) idling = 1'b0;
            else idling = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 85) begin
                is_fd = 1'($urandom_range(0, 1));
                if (!is_fd) len = 6'($urandom_range(0, 15));
                else if ($urandom_range(0, 9) == 0) len = 6'($urandom_range(0, 63));
                else len = 6'($urandom_range(0, 12));
                send_frame(is_fd, len, $urandom(), $urandom(), 8'($urandom_range(0, 255)),
                           2'($urandom_range(0, 3)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 2))
                        0: send_byte(SYNC_BYTE);
                        1: send_byte(REPLY_CODES[$urandom_range(0, 10)]);
                        default: send_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                // Bring the decoder back to waiting for a sync byte.
                while (dec_phase != PH_IDLE) begin
                    if (dec_phase == PH_CMD) send_byte(REPLY_CODES[$urandom_range(0, 10)]);
                    else send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        idling = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_command_codes();
        test_classic_frames();
        test_fd_frames();
        test_pause_for_results();
        test_random_traffic();
        wait_results_done();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/cfbd_pkg.sv
rtl/core/cfbd_core.sv
rtl/core/cfbd_out_reg.sv
rtl/core/can_frame_byte_deframer.sv
rtl/core/cfbd_checker.sv
tb/sv/tb_top.sv
